// ----- sv/bfm_pkg.sv -----
// Shared constants and types for the 5x5 box filter.
package bfm_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int SIZE_W   = 10;
  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT) + 1;
  localparam int LIN_W    = ROW_W + SIZE_W;
  localparam int WIN      = 5;
  localparam int WIN_RAD  = 2;
  localparam int LINES    = 4;
  localparam int SLOT_W   = $clog2(LINES);
  localparam int ROWSUM_W = PIX_W + $clog2(WIN);
  localparam int SUM_W    = PIX_W + $clog2(WIN * WIN);

  // Truncating division by 25 as a multiply by 5243 / 2^17, exact below 6376.
  localparam int DIV_MUL   = 5243;
  localparam int DIV_MUL_W = 13;
  localparam int DIV_SHIFT = 17;
  localparam int PROD_W    = SUM_W + DIV_MUL_W;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [LINES-1:0][PIX_W-1:0] line_word_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;
  typedef logic [ROWSUM_W-1:0] rowsum_t;

  // Control carried with an item from the memory read to the window update.
  typedef struct packed {
    logic              pixel;
    logic              emit;
    logic              interior;
    logic              last;
    logic [SLOT_W-1:0] row_slot;
    logic [SLOT_W-1:0] bord_slot;
    pixel_t            pix;
  } s1_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ----- sv/box_filter_5x5_mean.sv -----
// Top level of the streaming 5x5 mean filter with its line store and window pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_stall  | in_cmd, in_pixel_in
//  out     | output    | out_valid / out_stall| out_pixel_out, out_frame_end
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One item is taken per clock while in_stall is low; the line store is read at the edge
// that takes an item, then the window and row sums, the total, and the divide and select
// are registered in turn, the last of them into the output register.
// Reset is synchronous and clears counters and stage valids; sizes return to 512.
// The line store is not cleared: rows are always written before they are read.
// in_stall is high only while all three inner stages and the output register are full
// and the output is stalled.
module box_filter_5x5_mean (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [bfm_pkg::PIX_W-1:0]           in_pixel_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfm_pkg::PIX_W-1:0]           out_pixel_out,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfm_pkg::SIZE_W-1:0]          cfg_wdata
);

  localparam int LIN_W = bfm_pkg::LIN_W;

  // Configuration, kept already clamped.
  logic [bfm_pkg::SIZE_W-1:0] w_r, h_r;

  // Frame position counters.
  logic [bfm_pkg::COL_W-1:0] in_column_r, in_column_nxt;
  logic [bfm_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic [bfm_pkg::COL_W-1:0] out_column_r, out_column_nxt;
  logic [bfm_pkg::ROW_W-1:0] out_row_r, out_row_nxt;

  // Line store: four rows, one word per column holding all four slots.
  bfm_pkg::line_word_t line_mem [bfm_pkg::MAX_WIDTH];
  bfm_pkg::line_word_t rd_win_r, rd_bord_r;

  // Pipeline.
  logic              v1_r, v2_r, v3_r, out_valid_r;
  bfm_pkg::s1_ctl_t  s1_r;
  bfm_pkg::win_t     window_r, win_cur;
  bfm_pkg::rowsum_t  rowsum_cur [bfm_pkg::WIN];
  bfm_pkg::rowsum_t  rowsum_r [bfm_pkg::WIN];
  bfm_pkg::pixel_t   bord_cur;
  logic              s2_interior_r, s2_last_r;
  bfm_pkg::pixel_t   s2_bord_r;
  logic [bfm_pkg::SUM_W-1:0] total_nxt, total_r;
  logic              s3_interior_r, s3_last_r;
  bfm_pkg::pixel_t   s3_bord_r;
  logic [bfm_pkg::PROD_W-1:0] prod;
  bfm_pkg::pixel_t   mean;
  bfm_pkg::pixel_t   out_pixel_r;
  logic              out_frame_end_r;

  logic out_free, s3_free, s2_free, s1_free, s1_adv;
  logic in_acc;

  // Accept-stage decode.
  logic             complete, out_done, restart, is_pixel, emit, interior, frame_last;
  logic [LIN_W-1:0] in_lin, in_thresh, oc_inc, ic_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign s3_free  = !v3_r || out_free;
  assign s2_free  = !v2_r || s3_free;
  assign s1_free  = !v1_r || s2_free;
  assign s1_adv   = v1_r && s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && !in_stall;

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_frame_end_r;

  always_comb begin
    complete  = LIN_W'(in_row_r) >= LIN_W'(h_r);
    out_done  = LIN_W'(out_row_r) >= LIN_W'(h_r);
    restart   = complete && out_done;
    is_pixel  = (in_cmd == bfm_pkg::CMD_PIXEL) && !complete;
    in_lin    = LIN_W'(LIN_W'(in_row_r) * LIN_W'(w_r)) + LIN_W'(in_column_r);
    in_thresh = LIN_W'({w_r, 1'b0}) + LIN_W'(bfm_pkg::WIN_RAD);
    if (restart) begin
      emit = 1'b0;
    end else if (is_pixel) begin
      emit = (in_lin >= in_thresh) && !out_done;
    end else begin
      emit = complete && !out_done;
    end

    interior = (LIN_W'(out_row_r) >= LIN_W'(bfm_pkg::WIN_RAD))
            && (LIN_W'(out_row_r) + LIN_W'(bfm_pkg::WIN_RAD) < LIN_W'(h_r))
            && (LIN_W'(out_column_r) >= LIN_W'(bfm_pkg::WIN_RAD))
            && (LIN_W'(out_column_r) + LIN_W'(bfm_pkg::WIN_RAD) < LIN_W'(w_r));

    oc_inc         = LIN_W'(out_column_r) + LIN_W'(1);
    ic_inc         = LIN_W'(in_column_r) + LIN_W'(1);
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    frame_last     = 1'b0;

    if (emit) begin
      if (oc_inc >= LIN_W'(w_r)) begin
        out_column_nxt = '0;
        out_row_nxt    = out_row_r + 1'b1;
      end else begin
        out_column_nxt = bfm_pkg::COL_W'(oc_inc);
      end
      frame_last = LIN_W'(out_row_nxt) >= LIN_W'(h_r);
    end

    if (is_pixel) begin
      if (ic_inc >= LIN_W'(w_r)) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + 1'b1;
      end else begin
        in_column_nxt = bfm_pkg::COL_W'(ic_inc);
      end
    end

    // The last result of a frame, or a tick after it, starts the next frame.
    if (frame_last || restart) begin
      out_column_nxt = '0;
      out_row_nxt    = '0;
      in_column_nxt  = '0;
      in_row_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= bfm_pkg::SIZE_W'(bfm_pkg::MAX_WIDTH);
      h_r          <= bfm_pkg::SIZE_W'(bfm_pkg::MAX_HEIGHT);
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (bfm_pkg::cfg_reg_t'(cfg_index))
          bfm_pkg::CFG_FRAME_WIDTH: begin
            w_r <= bfm_pkg::clamp_size(cfg_wdata, bfm_pkg::SIZE_W'(bfm_pkg::MAX_WIDTH));
          end
          bfm_pkg::CFG_FRAME_HEIGHT: begin
            h_r <= bfm_pkg::clamp_size(cfg_wdata, bfm_pkg::SIZE_W'(bfm_pkg::MAX_HEIGHT));
          end
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        in_column_r  <= in_column_nxt;
        in_row_r     <= in_row_nxt;
        out_column_r <= out_column_nxt;
        out_row_r    <= out_row_nxt;
      end
    end
  end

  // Both reads see the store before this item's own write.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_win_r  <= line_mem[in_column_r];
      rd_bord_r <= line_mem[out_column_r];
      if (is_pixel) begin
        line_mem[in_column_r][in_row_r[bfm_pkg::SLOT_W-1:0]] <= in_pixel_in;
      end
    end
  end

  // Window shift and row sums for the item held in stage one.
  always_comb begin
    for (int k = 0; k < bfm_pkg::WIN; k++) begin
      for (int m = 0; m < bfm_pkg::WIN - 1; m++) begin
        win_cur[k][m] = s1_r.pixel ? window_r[k][m + 1] : window_r[k][m];
      end
    end
    for (int k = 0; k < bfm_pkg::WIN - 1; k++) begin
      win_cur[k][bfm_pkg::WIN - 1] = s1_r.pixel
        ? rd_win_r[s1_r.row_slot + bfm_pkg::SLOT_W'(k)]
        : window_r[k][bfm_pkg::WIN - 1];
    end
    win_cur[bfm_pkg::WIN - 1][bfm_pkg::WIN - 1] =
      s1_r.pixel ? s1_r.pix : window_r[bfm_pkg::WIN - 1][bfm_pkg::WIN - 1];
    for (int k = 0; k < bfm_pkg::WIN; k++) begin
      rowsum_cur[k] = '0;
      for (int m = 0; m < bfm_pkg::WIN; m++) begin
        rowsum_cur[k] = rowsum_cur[k] + bfm_pkg::ROWSUM_W'(win_cur[k][m]);
      end
    end
    bord_cur = rd_bord_r[s1_r.bord_slot];
  end

  always_comb begin
    total_nxt = '0;
    for (int k = 0; k < bfm_pkg::WIN; k++) begin
      total_nxt = total_nxt + bfm_pkg::SUM_W'(rowsum_r[k]);
    end
    prod = bfm_pkg::PROD_W'(total_r) * bfm_pkg::PROD_W'(bfm_pkg::DIV_MUL);
    mean = prod[bfm_pkg::DIV_SHIFT +: bfm_pkg::PIX_W];
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      if (s1_free) begin
        v1_r <= in_acc && (is_pixel || emit);
      end
      if (s2_free) begin
        v2_r <= v1_r && s1_r.emit;
      end
      if (s3_free) begin
        v3_r <= v2_r;
      end
      if (out_free) begin
        out_valid_r <= v3_r;
      end
      if (s1_adv) begin
        window_r <= win_cur;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.pixel     <= is_pixel;
      s1_r.emit      <= emit;
      s1_r.interior  <= interior;
      s1_r.last      <= frame_last;
      s1_r.row_slot  <= in_row_r[bfm_pkg::SLOT_W-1:0];
      s1_r.bord_slot <= out_row_r[bfm_pkg::SLOT_W-1:0];
      s1_r.pix       <= in_pixel_in;
    end
    if (s1_adv) begin
      rowsum_r      <= rowsum_cur;
      s2_interior_r <= s1_r.interior;
      s2_last_r     <= s1_r.last;
      s2_bord_r     <= bord_cur;
    end
    if (v2_r && s3_free) begin
      total_r       <= total_nxt;
      s3_interior_r <= s2_interior_r;
      s3_last_r     <= s2_last_r;
      s3_bord_r     <= s2_bord_r;
    end
    if (v3_r && out_free) begin
      out_pixel_r     <= s3_interior_r ? mean : s3_bord_r;
      out_frame_end_r <= s3_last_r;
    end
  end

  // The input side only holds off when every stage is full behind a stalled result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && v1_r && v2_r && v3_r))
    else $error("input stalled while the pipeline has room");

  // A pixel item always enters stage one.
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_pixel) |=> v1_r)
    else $error("accepted pixel item lost before the window");

  // The window takes the new pixel in its newest corner when a pixel item moves on.
  a_window_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.pixel) |=>
      (window_r[bfm_pkg::WIN - 1][bfm_pkg::WIN - 1] == $past(s1_r.pix)))
    else $error("window did not take the new pixel");

  // The last result of a frame returns all position counters to zero.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_last) |=>
      (in_row_r == '0 && in_column_r == '0 && out_row_r == '0 && out_column_r == '0))
    else $error("counters not cleared after the last result of a frame");

endmodule

// ----- verif/box_filter_5x5_mean_test.sv -----
// Self-checking testbench for the streaming 5x5 mean filter.
`timescale 1ns / 100ps

module box_filter_5x5_mean_test;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_WAIT    = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 280;
  localparam int CALM_FROM     = 220;
  localparam int HOLD_AT       = 200;
  localparam int LONG_HOLD     = 48;
  localparam int MAX_REPORTS   = 100;
  localparam int PLAN_ROWS     = 26;

  typedef struct packed {
    bfm_pkg::pixel_t pix;
    logic            last;
  } frame_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    bfm_pkg::cfg_reg_t          reg_idx;
    logic [bfm_pkg::SIZE_W-1:0] reg_val;
    logic                       cmd;
    bfm_pkg::pixel_t            pix;
    logic                       typed;
    logic                       has_res;
    bfm_pkg::pixel_t            res_pix;
    logic                       res_last;
  } plan_row_t;

  typedef enum int {FILL_NOISE, FILL_WHITE, FILL_BLACK, FILL_CHECKER, FILL_NARROW} fill_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic                       in_cmd      = bfm_pkg::CMD_DRAIN;
  bfm_pkg::pixel_t            in_pixel_in = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  bfm_pkg::pixel_t            out_pixel_out;
  logic                       out_frame_end;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  bfm_pkg::cfg_reg_t          cfg_index   = bfm_pkg::CFG_FRAME_WIDTH;
  logic [bfm_pkg::SIZE_W-1:0] cfg_wdata   = '0;

  box_filter_5x5_mean u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Filter state as the testbench sees it.
  bfm_pkg::pixel_t            line_mem [bfm_pkg::LINES*bfm_pkg::MAX_WIDTH];
  bfm_pkg::pixel_t            win_px   [bfm_pkg::WIN][bfm_pkg::WIN];
  int unsigned                rx_col, rx_row, tx_col, tx_row;
  logic [bfm_pkg::SIZE_W-1:0] reg_width, reg_height;

  frame_result_t expected_pixels [$];
  plan_row_t     plan [PLAN_ROWS];
  int            errors       = 0;
  int            results_seen = 0;
  int            frame_items  = 0;
  int            dead_cycles  = 0;
  bit            calm         = 1'b0;
  int            tx_quiet     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned bounded_size(input logic [bfm_pkg::SIZE_W-1:0] v,
                                               input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic rewind_frame();
    rx_col = 0;
    rx_row = 0;
    tx_col = 0;
    tx_row = 0;
  endtask

  // Advances the filter by one item; gives is set when the item yields a pixel.
  task automatic mean_filter_step(input logic cmd, input bfm_pkg::pixel_t pix,
                                  output bit gives, output frame_result_t res);
    int unsigned w, h, col, r, c, sum;
    bit          frame_full, takes_pixel, last_px;
    int          k, m;
    w = bounded_size(reg_width, bfm_pkg::MAX_WIDTH);
    h = bounded_size(reg_height, bfm_pkg::MAX_HEIGHT);
    frame_full = (rx_row >= h);
    takes_pixel = (cmd == bfm_pkg::CMD_PIXEL) && !frame_full;
    col = rx_col % bfm_pkg::MAX_WIDTH;
    last_px = 1'b0;
    gives = 1'b0;
    res = '0;
    if (frame_full && tx_row >= h) begin
      rewind_frame();
      return;
    end
    if (takes_pixel) begin
      for (k = 0; k < bfm_pkg::WIN; k++)
        for (m = 0; m < bfm_pkg::WIN - 1; m++)
          win_px[k][m] = win_px[k][m+1];
      for (k = 0; k < bfm_pkg::WIN - 1; k++)
        win_px[k][bfm_pkg::WIN-1] =
          line_mem[((rx_row + k) % bfm_pkg::LINES) * bfm_pkg::MAX_WIDTH + col];
      win_px[bfm_pkg::WIN-1][bfm_pkg::WIN-1] = pix;
      gives = (rx_row * w + rx_col >= bfm_pkg::WIN_RAD * w + bfm_pkg::WIN_RAD)
              && tx_row < h;
    end else begin
      gives = frame_full && tx_row < h;
    end
    if (gives) begin
      r = tx_row;
      c = tx_col % bfm_pkg::MAX_WIDTH;
      if (r >= bfm_pkg::WIN_RAD && r + bfm_pkg::WIN_RAD < h &&
          c >= bfm_pkg::WIN_RAD && c + bfm_pkg::WIN_RAD < w) begin
        sum = 0;
        for (k = 0; k < bfm_pkg::WIN; k++)
          for (m = 0; m < bfm_pkg::WIN; m++)
            sum += win_px[k][m];
        res.pix = bfm_pkg::pixel_t'(sum / (bfm_pkg::WIN * bfm_pkg::WIN));
      end else begin
        res.pix = line_mem[(r % bfm_pkg::LINES) * bfm_pkg::MAX_WIDTH + c];
      end
      tx_col++;
      if (tx_col >= w) begin
        tx_col = 0;
        tx_row++;
      end
      last_px = (tx_row >= h);
      res.last = last_px;
    end
    if (takes_pixel) begin
      line_mem[(rx_row % bfm_pkg::LINES) * bfm_pkg::MAX_WIDTH + col] = pix;
      rx_col++;
      if (rx_col >= w) begin
        rx_col = 0;
        rx_row++;
      end
    end
    if (last_px) rewind_frame();
  endtask

  // Offers one item, waits for it to be taken and records what it should produce.
  task automatic offer_item(input logic cmd, input bfm_pkg::pixel_t pix,
                            input bit typed = 1'b0, input bit t_has = 1'b0,
                            input frame_result_t t_res = '0);
    int            gap;
    bit            gives;
    frame_result_t res;
    gap = 0;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (!calm) begin
      if (tx_quiet > 0) tx_quiet--;
      else if ($urandom_range(0, 15) == 0) tx_quiet = $urandom_range(20, 80);
      else if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    mean_filter_step(cmd, pix, gives, res);
    if (typed) begin
      gives = t_has;
      res = t_res;
    end
    if (gives) expected_pixels.push_back(res);
  endtask

  // Lets the block run dry before its registers are touched.
  task automatic settle_block();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bfm_pkg::cfg_reg_t idx,
                           input logic [bfm_pkg::SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bfm_pkg::CFG_FRAME_WIDTH) reg_width = val;
    else reg_height = val;
  endtask

  task automatic run_frame(input logic [bfm_pkg::SIZE_W-1:0] w,
                           input logic [bfm_pkg::SIZE_W-1:0] h, input fill_t fill);
    int unsigned     npix, i;
    int              lead;
    bfm_pkg::pixel_t p;
    settle_block();
    write_reg(bfm_pkg::CFG_FRAME_WIDTH, w);
    write_reg(bfm_pkg::CFG_FRAME_HEIGHT, h);
    npix = bounded_size(w, bfm_pkg::MAX_WIDTH) * bounded_size(h, bfm_pkg::MAX_HEIGHT);
    // Drains ahead of the first pixel must be ignored.
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (lead) offer_item(bfm_pkg::CMD_DRAIN, bfm_pkg::pixel_t'($urandom_range(0, 255)));
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 11) == 0)
        offer_item(bfm_pkg::CMD_DRAIN, bfm_pkg::pixel_t'($urandom_range(0, 255)));
      case (fill)
        FILL_WHITE:   p = 8'hFF;
        FILL_BLACK:   p = 8'h00;
        FILL_CHECKER: p = (i % 2 == 0) ? 8'hFF : 8'h00;
        FILL_NARROW:  p = bfm_pkg::pixel_t'($urandom_range(96, 104));
        default:      p = bfm_pkg::pixel_t'($urandom_range(0, 255));
      endcase
      offer_item(bfm_pkg::CMD_PIXEL, p);
      frame_items++;
    end
    // Flush the tail; pixels offered now stand in for drains.
    while (rx_row != 0) begin
      offer_item(($urandom_range(0, 3) == 0) ? bfm_pkg::CMD_PIXEL : bfm_pkg::CMD_DRAIN,
                 bfm_pkg::pixel_t'($urandom_range(0, 255)));
      frame_items++;
    end
    if ($urandom_range(0, 4) == 0)
      offer_item(bfm_pkg::CMD_DRAIN, bfm_pkg::pixel_t'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      dead_cycles <= 0;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    wait (dead_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    int            hold;
    int            quiet;
    frame_result_t want;
    hold = 0;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got pixel %02h end %0b",
                     $time, out_pixel_out, out_frame_end);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_out !== want.pix) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: pixel_out mismatch, expected %02h, got %02h",
                       $time, want.pix, out_pixel_out);
          end
          if (out_frame_end !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: frame_end mismatch, expected %0b, got %0b",
                       $time, want.last, out_frame_end);
          end
        end
        // One long hold-off so the pipeline backs up into the input.
        if (results_seen == HOLD_AT) hold = LONG_HOLD;
      end
      if (hold == 0 && !calm) begin
        if (quiet > 0) quiet--;
        else if ($urandom_range(0, 19) == 0) quiet = $urandom_range(20, 80);
        else if ($urandom_range(0, 4) == 0) hold = $urandom_range(1, 4);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int                         i, k, m;
    bit                         prev_item;
    logic [bfm_pkg::SIZE_W-1:0] w, h;
    int                         r;
    fill_t                      fill;

    for (i = 0; i < bfm_pkg::LINES * bfm_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
    for (k = 0; k < bfm_pkg::WIN; k++)
      for (m = 0; m < bfm_pkg::WIN; m++)
        win_px[k][m] = '0;
    rewind_frame();
    reg_width  = bfm_pkg::SIZE_W'(bfm_pkg::MAX_WIDTH);
    reg_height = bfm_pkg::SIZE_W'(bfm_pkg::MAX_HEIGHT);

    plan = '{
      // Drain right after reset: the frame is still open, so nothing comes out.
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_REG, bfm_pkg::CFG_FRAME_WIDTH, 10'd1, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REG, bfm_pkg::CFG_FRAME_HEIGHT, 10'd1, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'hA5, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'hA5, 1'b1},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      // A width of zero acts as one.
      '{ROW_REG, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REG, bfm_pkg::CFG_FRAME_HEIGHT, 10'd2, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h3C, 1'b1, 1'b1, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
      // Frame narrower than the window: every pixel passes through on the flush.
      '{ROW_REG, bfm_pkg::CFG_FRAME_WIDTH, 10'd3, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_REG, bfm_pkg::CFG_FRAME_HEIGHT, 10'd2, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'hFE, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_PIXEL,
        8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'h01, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'hFF, 1'b1, 1'b1, 8'h80, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'hFE, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'h7F, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'h55, 1'b0},
      '{ROW_ITEM, bfm_pkg::CFG_FRAME_WIDTH, 10'd0, bfm_pkg::CMD_DRAIN,
        8'h00, 1'b1, 1'b1, 8'hAA, 1'b1}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    prev_item = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (prev_item) settle_block();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_item(plan[i].cmd, plan[i].pix, plan[i].typed, plan[i].has_res,
                   {plan[i].res_pix, plan[i].res_last});
      end
      prev_item = (plan[i].kind == ROW_ITEM);
    end

    // A height above the maximum clamps to it: one column at full height.
    run_frame(10'd1, 10'd1023, FILL_CHECKER);

    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      if (frame_items >= CALM_FROM) calm = 1'b1;
      r = $urandom_range(0, 9);
      if (r == 0) w = '0;
      else if (r == 1) w = bfm_pkg::SIZE_W'($urandom_range(13, 40));
      else w = bfm_pkg::SIZE_W'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) h = '0;
      else if (w > 12) h = bfm_pkg::SIZE_W'($urandom_range(1, 6));
      else h = bfm_pkg::SIZE_W'($urandom_range(1, 10));
      r = $urandom_range(0, 7);
      fill = (r < 4) ? FILL_NOISE : fill_t'(r - 3);
      run_frame(w, h, fill);
    end

    in_valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/bfm_pkg.sv
sv/box_filter_5x5_mean.sv
verif/box_filter_5x5_mean_test.sv
